@@ sv/fct_pkg.sv @@
`timescale 1ns / 1ps

package fct_pkg;

    // Title and parameter area sizes
    localparam int TITLE_LEN = 16;
    localparam int DATA_LEN  = 64;

    // Position counter covers the title limit and the last parameter slot
    localparam int POS_MAX = (TITLE_LEN > DATA_LEN - 1) ? TITLE_LEN : DATA_LEN - 1;
    localparam int POS_W   = $clog2(POS_MAX + 1);

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int FIELD_W = 6;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Token kinds
    localparam logic [KIND_W-1:0] TK_TITLE_CHAR = 3'd0;
    localparam logic [KIND_W-1:0] TK_TITLE_DONE = 3'd1;
    localparam logic [KIND_W-1:0] TK_PARAM_CHAR = 3'd2;
    localparam logic [KIND_W-1:0] TK_CMD_DONE   = 3'd3;
    localparam logic [KIND_W-1:0] TK_OVERFLOW   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END       = 2'd2;

    localparam logic [BYTE_W-1:0] BEGIN_RST     = 8'd60;
    localparam logic [BYTE_W-1:0] SEPARATOR_RST = 8'd44;
    localparam logic [BYTE_W-1:0] END_RST       = 8'd62;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TITLE,
        PH_PARAM
    } t_phase;

    typedef struct packed {
        logic              operation;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [BYTE_W-1:0]  char_out;
        logic [FIELD_W-1:0] param_index;
        logic [FIELD_W-1:0] char_position;
        logic [FIELD_W-1:0] field_count;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

endpackage

@@ sv/fct_in_stage.sv @@
`timescale 1ns / 1ps

module fct_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  fct_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_valid,
    output fct_pkg::t_in_item o_item
);

    logic              r_valid;
    fct_pkg::t_in_item r_item;

    // Free slot, or the held item leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

@@ sv/fct_core.sv @@
`timescale 1ns / 1ps

module fct_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fct_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fct_pkg::BYTE_W-1:0]          i_cfg_data,
    input  logic                                i_fire,
    input  fct_pkg::t_in_item                   i_item,
    output fct_pkg::t_result                    o_res
);

    logic [fct_pkg::BYTE_W-1:0] r_begin_byte;
    logic [fct_pkg::BYTE_W-1:0] r_separator_byte;
    logic [fct_pkg::BYTE_W-1:0] r_end_byte;

    fct_pkg::t_phase             r_phase, n_phase;
    logic [fct_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [fct_pkg::FIELD_W-1:0] r_sep_cnt, n_sep_cnt;
    logic [fct_pkg::FIELD_W-1:0] r_ne_idx, n_ne_idx;
    logic                        r_prev_char, n_prev_char;
    logic                        r_ready_flag, n_ready_flag;

    logic [fct_pkg::BYTE_W-1:0]  w_b;
    logic [fct_pkg::FIELD_W-1:0] w_cnt;

    assign w_b = i_item.rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_byte     <= fct_pkg::BEGIN_RST;
            r_separator_byte <= fct_pkg::SEPARATOR_RST;
            r_end_byte       <= fct_pkg::END_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fct_pkg::CFG_BEGIN:     r_begin_byte     <= i_cfg_data;
                fct_pkg::CFG_SEPARATOR: r_separator_byte <= i_cfg_data;
                fct_pkg::CFG_END:       r_end_byte       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= fct_pkg::PH_IDLE;
            r_pos        <= '0;
            r_sep_cnt    <= '0;
            r_ne_idx     <= '0;
            r_prev_char  <= 1'b0;
            r_ready_flag <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_sep_cnt    <= n_sep_cnt;
            r_ne_idx     <= n_ne_idx;
            r_prev_char  <= n_prev_char;
            r_ready_flag <= n_ready_flag;
        end
    end

    // A non-empty area with no separator still counts as one field
    assign w_cnt = ((r_pos != '0) && (r_sep_cnt == '0)) ? fct_pkg::FIELD_W'(1) : r_sep_cnt;

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_sep_cnt    = r_sep_cnt;
        n_ne_idx     = r_ne_idx;
        n_prev_char  = r_prev_char;
        n_ready_flag = r_ready_flag;
        o_res        = '0;

        if (i_fire) begin
            if (i_item.operation == fct_pkg::OP_RELEASE) begin
                n_ready_flag = 1'b0;
            end else if (!r_ready_flag) begin
                unique case (r_phase)
                    fct_pkg::PH_IDLE: begin
                        if (w_b == r_begin_byte) begin
                            n_phase     = fct_pkg::PH_TITLE;
                            n_pos       = '0;
                            n_sep_cnt   = '0;
                            n_ne_idx    = '0;
                            n_prev_char = 1'b0;
                        end
                    end
                    fct_pkg::PH_TITLE: begin
                        o_res.valid = 1'b1;
                        // Separator, or a byte past a full title: close the title
                        if (r_pos >= fct_pkg::POS_W'(fct_pkg::TITLE_LEN) ||
                            w_b == r_separator_byte) begin
                            n_phase               = fct_pkg::PH_PARAM;
                            n_pos                 = '0;
                            n_prev_char           = 1'b0;
                            o_res.item.token_kind = fct_pkg::TK_TITLE_DONE;
                        end else begin
                            o_res.item.token_kind    = fct_pkg::TK_TITLE_CHAR;
                            o_res.item.char_out      = w_b;
                            o_res.item.char_position = fct_pkg::FIELD_W'(r_pos);
                            n_pos                    = r_pos + fct_pkg::POS_W'(1);
                        end
                    end
                    default: begin
                        if (w_b == r_end_byte) begin
                            n_sep_cnt              = w_cnt;
                            o_res.valid            = 1'b1;
                            o_res.item.token_kind  = fct_pkg::TK_CMD_DONE;
                            o_res.item.field_count = w_cnt;
                            n_ready_flag           = 1'b1;
                            n_phase                = fct_pkg::PH_IDLE;
                            n_pos                  = '0;
                        end else if (w_b == r_separator_byte && r_pos == '0) begin
                            // drop leading separator
                        end else if (r_pos >= fct_pkg::POS_W'(fct_pkg::DATA_LEN - 1)) begin
                            o_res.valid              = 1'b1;
                            o_res.item.token_kind    = fct_pkg::TK_OVERFLOW;
                            o_res.item.char_position = fct_pkg::FIELD_W'(r_pos);
                        end else if (w_b == r_separator_byte) begin
                            n_sep_cnt = r_sep_cnt + fct_pkg::FIELD_W'(1);
                            if (r_pos != '0 && r_prev_char) begin
                                n_ne_idx = r_ne_idx + fct_pkg::FIELD_W'(1);
                            end
                            n_prev_char = 1'b0;
                            n_pos       = r_pos + fct_pkg::POS_W'(1);
                        end else begin
                            if (w_b == '0) begin
                                if (r_pos != '0 && r_prev_char) begin
                                    n_ne_idx = r_ne_idx + fct_pkg::FIELD_W'(1);
                                end
                                n_prev_char = 1'b0;
                            end else begin
                                n_prev_char = 1'b1;
                            end
                            o_res.valid              = 1'b1;
                            o_res.item.token_kind    = fct_pkg::TK_PARAM_CHAR;
                            o_res.item.char_out      = w_b;
                            o_res.item.param_index   = n_ne_idx;
                            o_res.item.char_position = fct_pkg::FIELD_W'(r_pos);
                            n_pos                    = r_pos + fct_pkg::POS_W'(1);
                        end
                    end
                endcase
            end
        end
    end

endmodule

@@ sv/fct_out_stage.sv @@
`timescale 1ns / 1ps

module fct_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  fct_pkg::t_result   i_res,
    input  logic               i_ready,
    output logic               o_free,
    output logic               o_valid,
    output fct_pkg::t_out_item o_item
);

    logic               r_valid;
    fct_pkg::t_out_item r_item;

    // Room for a new result when empty or when the held one transfers now
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res.valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_item <= i_res.item;
        end
    end

endmodule

@@ sv/framed_command_tokenizer.sv @@
`timescale 1ns / 1ps
// Path: an accepted input item waits in the input register, passes the parser logic and its
// result is loaded into the result register on o_out_item; it can transfer out at the next edge.
// Throughput: one item per cycle; the input stalls only while a result waits on i_out_ready.
// Reset (i_rst_n low, synchronous): parser idle, counters and ready flag
// cleared, begin/separator/end bytes back to 60/44/62, both stages empty.

module framed_command_tokenizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  fct_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output fct_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_we,
    input  logic [fct_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fct_pkg::BYTE_W-1:0]      i_cfg_data
);

    logic              w_in_valid;
    fct_pkg::t_in_item w_in_item;
    logic              w_out_free;
    logic              w_take;
    fct_pkg::t_result  w_res;

    // Advance the held item whenever the result register can take its output
    assign w_take = w_in_valid && w_out_free;

    fct_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_item  (w_in_item)
    );

    fct_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_take),
        .i_item      (w_in_item),
        .o_res       (w_res)
    );

    fct_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_take),
        .i_res   (w_res),
        .i_ready (i_out_ready),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

    // After command done, nothing is emitted until a release
    a_quiet_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_res.valid && w_res.item.token_kind == fct_pkg::TK_CMD_DONE)
        |=> !w_res.valid)
        else $error("token emitted while command waits for release");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.token_kind != fct_pkg::TK_TITLE_CHAR &&
         o_out_item.token_kind != fct_pkg::TK_PARAM_CHAR)
        |-> o_out_item.char_out == '0)
        else $error("non-character token carries a byte");

    a_overflow_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.token_kind == fct_pkg::TK_OVERFLOW)
        |-> o_out_item.char_position == fct_pkg::FIELD_W'(fct_pkg::DATA_LEN - 1))
        else $error("overflow token at wrong position");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && !w_take) |=> w_in_valid)
        else $error("held input item lost");

endmodule
